// ===== rtl/fmeg_pkg.sv =====
// ----------------------------------------------------------------------------
// fmeg_pkg
// Shared types and constants of the FM envelope generator.
// ----------------------------------------------------------------------------
package fmeg_pkg;

    localparam logic [6:0] ATTN_CEILING   = 7'd127;
    localparam logic [6:0] ATTN_MUTE_BITS = 7'd124;
    localparam logic [6:0] RATE_CEILING   = 7'd63;

    // Step patterns, bit i is entry i of the pattern row
    localparam logic [7:0] STEP_PATTERN [4] = '{8'hAA, 8'hBA, 8'hEE, 8'hFE};

    typedef enum logic [1:0] {
        ST_DAMP    = 2'd0,
        ST_ATTACK  = 2'd1,
        ST_DECAY   = 2'd2,
        ST_SUSTAIN = 2'd3
    } env_stage_t;

    typedef struct packed {
        logic [4:0] op_index;
        logic       sample_end;
        logic [3:0] attack_rate;
        logic [3:0] decay_rate;
        logic [3:0] sustain_level;
        logic [3:0] release_rate;
        logic       sustained_tone;
        logic       key_scale_rate;
        logic [3:0] key_code;
        logic       key_on;
        logic       sustain_mode;
        logic       rhythm_operator;
    } fmeg_in_t;

    typedef struct packed {
        logic [6:0] attenuation;
        logic [1:0] envelope_phase;
        logic       phase_reset;
        logic       silent;
    } fmeg_out_t;

    // Per-operator state
    typedef struct packed {
        logic [6:0] level;
        env_stage_t stage;
        logic       key;
    } op_state_t;

    // One memory row holds both operators of a channel
    typedef struct packed {
        op_state_t modu;
        op_state_t carr;
    } chan_row_t;

    localparam op_state_t OP_RESET  = '{level: ATTN_CEILING, stage: ST_SUSTAIN, key: 1'b0};
    localparam chan_row_t ROW_RESET = '{modu: OP_RESET, carr: OP_RESET};

    localparam fmeg_out_t OUT_IDLE_OP = '{
        attenuation:    ATTN_CEILING,
        envelope_phase: ST_SUSTAIN,
        phase_reset:    1'b0,
        silent:         1'b1
    };

endpackage

// ===== rtl/fm_envelope_generator_unit.sv =====
// ----------------------------------------------------------------------------
// fm_envelope_generator_unit
// Envelope generator for 2*NUM_CHANNELS FM operators, one operator a transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry one operator update request a transfer:
//   operator index, its rates, sustain level, key code and mode bits.
//   m_valid/m_ready/m_item return one result per request, in order: new
//   attenuation, envelope phase, phase reset flag and silence flag.
// Path: read stage register, then output register. Throughput: one operator
//   per clock unless the output stalls. The state of both operators of a
//   channel sits in one row of a single-port-write memory with a registered
//   read port; each request reads its row on acceptance and writes it back
//   as its result is registered. A back-to-back request to the same channel
//   takes the row from a forwarding register holding the last write.
// Reset: synchronous, active low. Every operator reads as attenuation 127,
//   sustain phase, key released; a per-row valid bit stands in for the
//   memory until the row is first written, so no clearing pass is needed.
//   The 16-bit sample counter clears and steps on each result with
//   sample_end set.
// Stall: with m_ready low the result holds in the output register; one
//   further request is taken and parked in the read stage, then s_ready
//   drops until the output register drains.
// Operator indices at or beyond 2*NUM_CHANNELS leave all operator state
//   alone and return a muted result.
// ----------------------------------------------------------------------------
module fm_envelope_generator_unit #(
    parameter int NUM_CHANNELS = 9
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fmeg_pkg::fmeg_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output fmeg_pkg::fmeg_out_t m_item
);

    localparam int ROW_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int OP_COUNT = 2 * NUM_CHANNELS;

    // read stage
    logic                p1_valid_reg, p1_valid_next;
    fmeg_pkg::fmeg_in_t  p1_item_reg;
    logic                p1_in_range;
    logic [ROW_W-1:0]    p1_row;
    logic                p1_adv;

    // input side
    logic                s_xfer;
    logic                s_in_range;
    logic [ROW_W-1:0]    rd_addr;

    // memory and forwarding
    fmeg_pkg::chan_row_t rd_row;
    fmeg_pkg::chan_row_t row_use;
    fmeg_pkg::chan_row_t row_new;
    logic                wr_en;
    logic                fwd_valid_reg;
    logic [ROW_W-1:0]    fwd_addr_reg;
    fmeg_pkg::chan_row_t fwd_row_reg;

    // counter and output register
    logic [15:0]         cnt_reg, cnt_next;
    fmeg_pkg::fmeg_out_t calc_result;
    logic                m_valid_reg, m_valid_next;
    fmeg_pkg::fmeg_out_t m_item_reg;

    assign s_in_range  = ({1'b0, s_item.op_index} < 6'(OP_COUNT));
    assign p1_in_range = ({1'b0, p1_item_reg.op_index} < 6'(OP_COUNT));
    assign rd_addr     = s_in_range ? s_item.op_index[ROW_W:1] : '0;
    assign p1_row      = p1_item_reg.op_index[ROW_W:1];

    // the output register takes a result whenever it is empty or draining
    assign p1_adv  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;
    assign wr_en   = p1_adv && p1_in_range;

    // last written row overrides a stale read of the same row
    assign row_use = (fwd_valid_reg && fwd_addr_reg == p1_row) ? fwd_row_reg : rd_row;

    fmeg_state_mem #(
        .DEPTH  (NUM_CHANNELS),
        .ADDR_W (ROW_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_xfer),
        .rd_addr (rd_addr),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (p1_row),
        .wr_data (row_new)
    );

    fmeg_env_calc u_calc (
        .item    (p1_item_reg),
        .row     (row_use),
        .cnt     (cnt_reg),
        .row_new (row_new),
        .result  (calc_result)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_xfer) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (p1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        cnt_next = cnt_reg;
        if (p1_adv && p1_item_reg.sample_end) begin
            cnt_next = cnt_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
            cnt_reg      <= cnt_next;
            if (wr_en) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            p1_item_reg <= s_item;
        end
        if (wr_en) begin
            fwd_addr_reg <= p1_row;
            fwd_row_reg  <= row_new;
        end
        if (p1_adv) begin
            m_item_reg <= p1_in_range ? calc_result : fmeg_pkg::OUT_IDLE_OP;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== rtl/fmeg_state_mem.sv =====
// ----------------------------------------------------------------------------
// fmeg_state_mem
// Channel state memory: one write port, one registered read port; rows
// never written since reset read back as the reset state.
// ----------------------------------------------------------------------------
module fmeg_state_mem #(
    parameter int DEPTH  = 9,
    parameter int ADDR_W = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output fmeg_pkg::chan_row_t       rd_data,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  fmeg_pkg::chan_row_t       wr_data
);

    fmeg_pkg::chan_row_t mem [DEPTH];
    fmeg_pkg::chan_row_t rd_data_reg;
    logic [DEPTH-1:0]    vld_reg;
    logic                rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : fmeg_pkg::ROW_RESET;

endmodule

// ===== rtl/fmeg_env_calc.sv =====
// ----------------------------------------------------------------------------
// fmeg_env_calc
// Envelope update for one operator: key edge, phase change, effective rate
// and attenuation step. Produces the new channel row and the result.
// ----------------------------------------------------------------------------
module fmeg_env_calc (
    input  fmeg_pkg::fmeg_in_t  item,
    input  fmeg_pkg::chan_row_t row,
    input  logic [15:0]         cnt,
    output fmeg_pkg::chan_row_t row_new,
    output fmeg_pkg::fmeg_out_t result
);

    logic                 carrier;
    logic                 tone_path;
    logic                 restart;
    logic                 mod_write;
    logic                 attack;
    fmeg_pkg::op_state_t  own;
    fmeg_pkg::op_state_t  own_new;
    fmeg_pkg::op_state_t  mod_new;
    fmeg_pkg::env_stage_t stg;
    logic [6:0]           env;
    logic [7:0]           env_n;
    logic [3:0]           base;
    logic [6:0]           rate_sum;
    logic [5:0]           rate;
    logic [3:0]           grp;
    logic [7:0]           pat;
    logic [3:0]           sh;
    logic [2:0]           fm;
    logic [15:0]          mask;
    logic [15:0]          shifted;

    always_comb begin
        carrier   = item.op_index[0];
        tone_path = item.rhythm_operator | carrier;
        own       = carrier ? row.carr : row.modu;
        stg       = (item.key_on && !own.key) ? fmeg_pkg::ST_DAMP : own.stage;
        env       = own.level;
        restart   = 1'b0;

        if (stg == fmeg_pkg::ST_DAMP && env[6:2] == 5'h1f && tone_path) begin
            restart = 1'b1;
            if (item.attack_rate == 4'hf) begin
                stg = fmeg_pkg::ST_DECAY;
                env = '0;
            end else begin
                stg = fmeg_pkg::ST_ATTACK;
            end
        end else if (stg == fmeg_pkg::ST_ATTACK && env == 7'd0) begin
            stg = fmeg_pkg::ST_DECAY;
        end else if (stg == fmeg_pkg::ST_DECAY && env[6:3] == item.sustain_level) begin
            stg = fmeg_pkg::ST_SUSTAIN;
        end

        // melodic carrier restart carries over to its modulator
        mod_write = restart && carrier && !item.rhythm_operator;
        mod_new   = row.modu;
        if (mod_write) begin
            mod_new.stage = stg;
            if (item.attack_rate == 4'hf) begin
                mod_new.level = '0;
            end
        end

        // base rate
        attack = 1'b0;
        if (!item.key_on && tone_path) begin
            base = item.sustained_tone ? item.release_rate
                                       : (item.sustain_mode ? 4'd5 : 4'd7);
        end else begin
            unique case (stg)
                fmeg_pkg::ST_DAMP:   base = 4'd12;
                fmeg_pkg::ST_ATTACK: begin
                    base   = item.attack_rate;
                    attack = 1'b1;
                end
                fmeg_pkg::ST_DECAY:  base = item.decay_rate;
                default:             base = item.sustained_tone ? 4'd0 : item.release_rate;
            endcase
        end

        rate_sum = {1'b0, base, 2'b00}
                 + (item.key_scale_rate ? {3'b000, item.key_code}
                                        : {5'b00000, item.key_code[3:2]});
        rate     = (rate_sum > fmeg_pkg::RATE_CEILING) ? 6'd63 : rate_sum[5:0];
        grp      = rate[5:2];
        pat      = fmeg_pkg::STEP_PATTERN[rate[1:0]];
        sh       = 4'd13 - grp;
        fm       = 3'(5'd16 - {1'b0, grp});
        mask     = (16'h0001 << sh) - 16'h0001;
        shifted  = cnt >> sh;
        env_n    = {1'b0, env};

        if (attack) begin
            if (grp == 4'd0 || grp == 4'd15) begin
                env_n = '0;
            end else if (grp >= 4'd12) begin
                env_n = (env == 7'd0) ? 8'd0 : {1'b0, env - (env >> fm) - 7'd1};
            end else if ((cnt & mask & ~16'h0003) == 16'h0000 && pat[shifted[2:0]]) begin
                env_n = (env == 7'd0) ? 8'd0 : {1'b0, env - (env >> 4) - 7'd1};
            end
        end else begin
            if (grp == 4'd0) begin
                env_n = {1'b0, env};
            end else if (grp == 4'd13) begin
                env_n = {1'b0, env} + 8'd1 + {7'd0, pat[{cnt[3:2], cnt[0]}]};
            end else if (grp == 4'd14) begin
                env_n = {1'b0, env} + 8'd1 + {7'd0, pat[{cnt[3:2], 1'b0}]};
            end else if (grp == 4'd15) begin
                env_n = {1'b0, env} + 8'd2;
            end else if ((cnt & mask) == 16'h0000) begin
                env_n = {1'b0, env} + {7'd0, pat[shifted[2:0]]};
            end
            if (env_n > {1'b0, fmeg_pkg::ATTN_CEILING}) begin
                env_n = {1'b0, fmeg_pkg::ATTN_CEILING};
            end
        end

        own_new.level = env_n[6:0];
        own_new.stage = stg;
        own_new.key   = item.key_on;

        if (carrier) begin
            row_new.carr = own_new;
            row_new.modu = mod_new;
        end else begin
            row_new.carr = row.carr;
            row_new.modu = own_new;
        end

        result.attenuation    = env_n[6:0];
        result.envelope_phase = stg;
        result.phase_reset    = restart;
        result.silent         = ((env_n[6:0] & fmeg_pkg::ATTN_MUTE_BITS)
                                 == fmeg_pkg::ATTN_MUTE_BITS);
    end

endmodule

// ===== rtl/fmeg_checker.sv =====
// ----------------------------------------------------------------------------
// fmeg_checker
// Port-level checks of the envelope generator, bound to the top level.
// ----------------------------------------------------------------------------
module fmeg_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input fmeg_pkg::fmeg_out_t m_item
);

    // a held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // input backpressure only comes from a stalled full output
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // silence flag agrees with the attenuation
    a_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.silent == (m_item.attenuation[6:2] == 5'h1f))
        else $error("silent flag mismatch");

    // a restart lands in attack or decay
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.phase_reset |->
            (m_item.envelope_phase == fmeg_pkg::ST_ATTACK ||
             m_item.envelope_phase == fmeg_pkg::ST_DECAY))
        else $error("phase reset outside attack or decay");

endmodule

bind fm_envelope_generator_unit fmeg_checker u_fmeg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
